/* design/assert_macros.svh */
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// check on every clock edge outside reset
`define SSEL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define SSEL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SSEL_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSEL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* design/ssel_pkg.sv */
// shared types and constants of the sorted edge list core
package ssel_pkg;

    localparam int CMD_W    = 2;
    localparam int WIN_W    = 16;
    localparam int NODE_W   = 5;
    localparam int WEIGHT_W = 15;
    localparam int ID_W     = 9;
    localparam int NCFG_W   = 6;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0]   node_low;
        logic [NODE_W-1:0]   node_high;
        logic [WEIGHT_W-1:0] weight;
        logic [ID_W-1:0]     id;
    } edge_entry_t;

    // broadcast from the controller to every cell of the chain
    typedef struct packed {
        logic        insert;
        logic        read_en;
        edge_entry_t new_entry;
    } cell_ctrl_t;

endpackage

/* design/ssel_if.sv */
// handshake channels for commands in and sorted edges out

interface ssel_in_if;
    logic                                valid;
    logic                                ready;
    logic [ssel_pkg::CMD_W-1:0]          cmd;
    logic signed [ssel_pkg::WIN_W-1:0]   weight_in;

    modport source (output valid, output cmd, output weight_in, input ready);
    modport sink   (input valid, input cmd, input weight_in, output ready);
endinterface

interface ssel_out_if;
    logic                               valid;
    logic                               ready;
    logic                               edge_valid;
    logic [ssel_pkg::NODE_W-1:0]        node_low;
    logic [ssel_pkg::NODE_W-1:0]        node_high;
    logic [ssel_pkg::WEIGHT_W-1:0]      edge_weight;
    logic [ssel_pkg::ID_W-1:0]          edge_id;
    logic                               last_edge;

    modport source (output valid, output edge_valid, output node_low, output node_high,
                    output edge_weight, output edge_id, output last_edge, input ready);
    modport sink   (input valid, input edge_valid, input node_low, input node_high,
                    input edge_weight, input edge_id, input last_edge, output ready);
endinterface

/* design/ssel_cell.sv */
// one slot of the insertion chain plus one stage of the readout line
module ssel_cell #(
    parameter int IDX = 0,
    parameter int CW  = 10
) (
    input  logic                  clk,
    input  ssel_pkg::cell_ctrl_t  ctrl,
    input  logic [CW-1:0]         count,
    input  logic [CW-1:0]         rd_ptr,
    input  ssel_pkg::edge_entry_t left_entry,
    input  logic                  left_moves,
    input  ssel_pkg::edge_entry_t right_bus,
    output ssel_pkg::edge_entry_t entry,
    output logic                  moves,
    output ssel_pkg::edge_entry_t bus
);
    import ssel_pkg::*;

    edge_entry_t entry_reg;
    edge_entry_t entry_next;
    edge_entry_t bus_reg;
    edge_entry_t bus_next;
    logic        occupied;
    logic        left_occupied;
    logic        take_new;
    logic        hit;

    // slots below the fill count hold edges
    assign occupied      = (count > CW'(IDX));
    assign left_occupied = (IDX == 0) ? 1'b1 : (count >= CW'(IDX));

    // strictly greater weight moves up, so equal weights keep arrival order
    assign moves    = occupied && (entry_reg.weight > ctrl.new_entry.weight);
    assign take_new = !left_moves && (moves || (!occupied && left_occupied));
    assign hit      = ctrl.read_en && (rd_ptr == CW'(IDX));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            priority if (left_moves)
            begin
                entry_next = left_entry;
            end
            else if (take_new)
            begin
                entry_next = ctrl.new_entry;
            end
            else
            begin
                entry_next = entry_reg;
            end
        end
    end

    // readout line runs towards slot zero, one slot per cycle
    assign bus_next = hit ? entry_reg : right_bus;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        bus_reg   <= bus_next;
    end

    assign entry = entry_reg;
    assign bus   = bus_reg;

endmodule

/* design/ssel_chain.sv */
// row of insertion cells holding the table in ascending weight order
module ssel_chain #(
    parameter int N  = 512,
    parameter int CW = 10
) (
    input  logic                  clk,
    input  ssel_pkg::cell_ctrl_t  ctrl,
    input  logic [CW-1:0]         count,
    input  logic [CW-1:0]         rd_ptr,
    output ssel_pkg::edge_entry_t head
);
    import ssel_pkg::*;

    edge_entry_t entry_w [N];
    edge_entry_t bus_w   [N];
    logic        moves_w [N];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        edge_entry_t left_entry;
        logic        left_moves;
        edge_entry_t right_bus;

        if (i == 0)
        begin : g_first
            assign left_entry = '0;
            assign left_moves = 1'b0;
        end
        else
        begin : g_inner
            assign left_entry = entry_w[i-1];
            assign left_moves = moves_w[i-1];
        end

        if (i == N - 1)
        begin : g_last
            assign right_bus = '0;
        end
        else
        begin : g_mid
            assign right_bus = bus_w[i+1];
        end

        ssel_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count),
            .rd_ptr     (rd_ptr),
            .left_entry (left_entry),
            .left_moves (left_moves),
            .right_bus  (right_bus),
            .entry      (entry_w[i]),
            .moves      (moves_w[i]),
            .bus        (bus_w[i])
        );
    end

    assign head = bus_w[0];

endmodule

/* design/similarity_to_sorted_edge_list_core.sv */
// top level: command decode, matrix counters, read sequencer and output register
//
// Weights of the upper triangle arrive one load transaction at a time in row-major
// order; each positive one is placed, while the chain has room, into a chain of
// MAX_EDGES cells, all cells comparing against the new weight in parallel and shifting
// up by one where needed. A read transaction fetches the entry at the read pointer
// over a registered readout line that runs through the cells towards slot zero, one
// cell per cycle, into the output register. No new transaction is taken while a read
// is in flight; a finished result waits in the output register while loads and clears
// go on. The user writes node_count through cfg_wr_en / cfg_wr_data only while the
// block is idle; the block itself does not enforce this.
module similarity_to_sorted_edge_list_core #(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ssel_pkg::NCFG_W-1:0]   cfg_wr_data,
    ssel_in_if.sink                       in_ch,
    ssel_out_if.source                    out_ch
);
    import ssel_pkg::*;

    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int RW = $clog2(MAX_NODES + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [NCFG_W-1:0] node_count_reg, node_count_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [RW-1:0]    col_reg, col_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    kept_count_reg, kept_count_next;
    logic [CW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             empty_reg, empty_next;
    logic             out_valid_reg, out_valid_next;
    edge_entry_t      out_entry_reg, out_entry_next;
    logic             out_edge_valid_reg, out_edge_valid_next;
    logic             out_last_reg, out_last_next;

    logic             accept;
    logic             out_free;
    logic             out_load;
    logic [RW-1:0]    n_eff;
    logic             in_matrix;
    logic             positive;
    logic             not_full;
    logic [RW-1:0]    col_inc;
    logic [RW-1:0]    col_wrap;
    cell_ctrl_t       ctrl;
    edge_entry_t      head;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign out_load    = (state_reg == ST_DRAIN) && out_free;

    // node count clamped into the supported range
    always_comb
    begin
        priority if (node_count_reg < NCFG_W'(2))
        begin
            n_eff = RW'(2);
        end
        else if ({1'b0, node_count_reg} > (NCFG_W + 1)'(MAX_NODES))
        begin
            n_eff = RW'(MAX_NODES);
        end
        else
        begin
            n_eff = RW'(node_count_reg);
        end
    end

    assign in_matrix = !done_reg && (col_reg < n_eff) && (row_reg < n_eff);
    assign positive  = !in_ch.weight_in[WIN_W-1] && (in_ch.weight_in[WEIGHT_W-1:0] != '0);
    assign not_full  = (kept_count_reg < CW'(MAX_EDGES));
    assign col_inc   = col_reg + 1'b1;
    assign col_wrap  = row_reg + RW'(2);

    assign ctrl.insert              = accept && (in_ch.cmd == CMD_LOAD) && in_matrix
                                      && positive && not_full;
    assign ctrl.read_en             = (state_reg == ST_READ) || (state_reg == ST_DRAIN);
    assign ctrl.new_entry.node_low  = NODE_W'(row_reg);
    assign ctrl.new_entry.node_high = NODE_W'(col_reg);
    assign ctrl.new_entry.weight    = in_ch.weight_in[WEIGHT_W-1:0];
    assign ctrl.new_entry.id        = ID_W'(kept_count_reg);

    ssel_chain #(
        .N  (MAX_EDGES),
        .CW (CW)
    ) u_chain (
        .clk    (clk),
        .ctrl   (ctrl),
        .count  (kept_count_reg),
        .rd_ptr (rd_ptr_reg),
        .head   (head)
    );

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        done_next       = done_reg;
        kept_count_next = kept_count_reg;
        rd_ptr_next     = rd_ptr_reg;
        cnt_next        = cnt_reg;
        empty_next      = empty_reg;

        if (cfg_wr_en)
        begin
            node_count_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_ch.cmd)
                        CMD_CLEAR:
                        begin
                            row_next        = '0;
                            col_next        = RW'(1);
                            done_next       = 1'b0;
                            kept_count_next = '0;
                            rd_ptr_next     = '0;
                        end
                        CMD_LOAD:
                        begin
                            if (!in_matrix)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                if (ctrl.insert)
                                begin
                                    kept_count_next = kept_count_reg + 1'b1;
                                end
                                if (col_inc >= n_eff)
                                begin
                                    row_next = row_reg + 1'b1;
                                    col_next = col_wrap;
                                    if (col_wrap >= n_eff)
                                    begin
                                        done_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    col_next = col_inc;
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            cnt_next = '0;
                            if (rd_ptr_reg < kept_count_reg)
                            begin
                                empty_next = 1'b0;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                empty_next = 1'b1;
                                state_next = ST_DRAIN;
                            end
                        end
                        default:
                        begin
                            // unused command code, dropped
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // wait here while the hit cell's entry runs down the readout line towards slot zero
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == rd_ptr_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    if (!empty_reg)
                    begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next      = out_valid_reg;
        out_entry_next      = out_entry_reg;
        out_edge_valid_next = out_edge_valid_reg;
        out_last_next       = out_last_reg;
        if (out_load)
        begin
            out_valid_next      = 1'b1;
            out_entry_next      = empty_reg ? '0 : head;
            out_edge_valid_next = !empty_reg;
            out_last_next       = !empty_reg && ((rd_ptr_reg + 1'b1) == kept_count_reg);
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NCFG_W'(32);
            row_reg        <= '0;
            col_reg        <= RW'(1);
            done_reg       <= 1'b0;
            kept_count_reg <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
            empty_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            done_reg       <= done_next;
            kept_count_reg <= kept_count_next;
            rd_ptr_reg     <= rd_ptr_next;
            cnt_reg        <= cnt_next;
            empty_reg      <= empty_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_entry_reg      <= out_entry_next;
        out_edge_valid_reg <= out_edge_valid_next;
        out_last_reg       <= out_last_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.edge_valid  = out_edge_valid_reg;
    assign out_ch.node_low    = out_entry_reg.node_low;
    assign out_ch.node_high   = out_entry_reg.node_high;
    assign out_ch.edge_weight = out_entry_reg.weight;
    assign out_ch.edge_id     = out_entry_reg.id;
    assign out_ch.last_edge   = out_last_reg;

    `include "assert_macros.svh"

    `SSEL_ASSERT_ALWAYS(a_kept_bound, clk, kept_count_reg <= CW'(MAX_EDGES), "fill count too big")
    `SSEL_ASSERT(a_ptr_bound, clk, rst_n, rd_ptr_reg <= kept_count_reg, "read pointer too big")
    `SSEL_ASSERT(a_cnt_bound, clk, rst_n, (state_reg == ST_READ) |-> (cnt_reg <= rd_ptr_reg), "overrun")
    `SSEL_ASSERT(a_out_src, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == ST_DRAIN), "no read")

endmodule

/* dv/similarity_to_sorted_edge_list_core_test.sv */
// testbench for the similarity matrix to sorted edge list core
`timescale 1ns / 1ps

module similarity_to_sorted_edge_list_core_test;
    import ssel_pkg::*;

    localparam int MATRIX_NODES  = 32;
    localparam int EDGE_SLOTS    = 512;
    localparam int ITEM_TARGET   = 1150;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 2_000_000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic        edge_valid;
        edge_entry_t ent;
        logic        last_edge;
    } edge_result_t;

    typedef enum logic {ROW_CMD, ROW_NODES} row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CMD_W-1:0]         cmd;
        logic signed [WIN_W-1:0]  weight;
        logic [NCFG_W-1:0]        nodes;
        logic                     typed;
        edge_result_t             result;
    } stim_row_t;

    localparam edge_result_t NO_EDGE  = '0;
    localparam edge_result_t TOP_EDGE = '{1'b1, '{5'd0, 5'd1, 15'h7FFF, 9'd0}, 1'b1};

    localparam int DIRECTED_ROWS = 27;

    // typed results only where they are obvious; the rest goes through the predictor
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_CMD,   CMD_READ,   16'h0000, 6'd0,  1'b1, NO_EDGE},
        '{ROW_CMD,   CMD_UNUSED, 16'hFFFF, 6'd0,  1'b0, NO_EDGE},
        '{ROW_NODES, CMD_CLEAR,  16'h0000, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_LOAD,   16'h7FFF, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_LOAD,   16'h0001, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_READ,   16'h0000, 6'd0,  1'b1, TOP_EDGE},
        '{ROW_CMD,   CMD_READ,   16'h0000, 6'd0,  1'b1, NO_EDGE},
        '{ROW_CMD,   CMD_CLEAR,  16'h0000, 6'd0,  1'b0, NO_EDGE},
        '{ROW_NODES, CMD_CLEAR,  16'h0000, 6'd4,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_LOAD,   16'h8000, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_LOAD,   16'h0000, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_LOAD,   16'h0001, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_LOAD,   16'h0001, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_LOAD,   16'hFFFF, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_READ,   16'h0000, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_LOAD,   16'h4000, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_READ,   16'h0000, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_READ,   16'h0000, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_READ,   16'h0000, 6'd0,  1'b1, NO_EDGE},
        '{ROW_NODES, CMD_CLEAR,  16'h0000, 6'd63, 1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_CLEAR,  16'h0000, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_LOAD,   16'h0100, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_LOAD,   16'h0080, 6'd0,  1'b0, NO_EDGE},
        '{ROW_NODES, CMD_CLEAR,  16'h0000, 6'd2,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_LOAD,   16'h7000, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_READ,   16'h0000, 6'd0,  1'b0, NO_EDGE},
        '{ROW_CMD,   CMD_READ,   16'h0000, 6'd0,  1'b0, NO_EDGE}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [NCFG_W-1:0] cfg_wr_data;

    ssel_in_if  in_ch ();
    ssel_out_if out_ch ();

    similarity_to_sorted_edge_list_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // predictor state
    edge_entry_t       sorted_edges [$];
    int unsigned       row_idx;
    int unsigned       col_idx;
    int unsigned       kept_edges;
    int unsigned       read_ptr;
    bit                triangle_done;
    logic [NCFG_W-1:0] node_cfg;

    edge_result_t expected_edges [$];
    int unsigned  mismatches;
    int unsigned  useful_items;
    int unsigned  cycle_count;
    bit           idling;
    bit           hold_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned nodes_in_use();
        if (node_cfg < 2) return 2;
        if (node_cfg > MATRIX_NODES) return MATRIX_NODES;
        return node_cfg;
    endfunction

    function automatic void clear_matrix();
        sorted_edges.delete();
        row_idx       = 0;
        col_idx       = 1;
        kept_edges    = 0;
        read_ptr      = 0;
        triangle_done = 1'b0;
    endfunction

    // returns 0 when the load falls beyond the end of the triangle
    function automatic bit sort_in_weight(input logic signed [WIN_W-1:0] weight);
        int unsigned n;
        int unsigned pos;
        edge_entry_t ent;
        n = nodes_in_use();
        if (triangle_done || col_idx >= n || row_idx >= n)
        begin
            triangle_done = 1'b1;
            return 1'b0;
        end
        if (!weight[WIN_W-1] && weight[WEIGHT_W-1:0] != 0 && kept_edges < EDGE_SLOTS)
        begin
            // stable: goes after every entry of equal or lower weight
            pos = sorted_edges.size();
            while (pos > 0 && sorted_edges[pos-1].weight > weight[WEIGHT_W-1:0])
                pos--;
            ent.node_low  = NODE_W'(row_idx);
            ent.node_high = NODE_W'(col_idx);
            ent.weight    = weight[WEIGHT_W-1:0];
            ent.id        = ID_W'(kept_edges);
            sorted_edges.insert(pos, ent);
            kept_edges++;
        end
        col_idx++;
        if (col_idx >= n)
        begin
            row_idx++;
            col_idx = row_idx + 1;
            if (col_idx >= n) triangle_done = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic edge_result_t next_sorted_edge();
        edge_result_t res;
        res = NO_EDGE;
        if (read_ptr < kept_edges)
        begin
            res.edge_valid = 1'b1;
            res.ent        = sorted_edges[read_ptr];
            res.last_edge  = (read_ptr + 1 == kept_edges);
            read_ptr++;
        end
        return res;
    endfunction

    function automatic string edge_text(input edge_result_t e);
        return $sformatf("valid=%0b low=%0d high=%0d weight=%0d id=%0d last=%0b",
                         e.edge_valid, e.ent.node_low, e.ent.node_high, e.ent.weight,
                         e.ent.id, e.last_edge);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idling) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [WIN_W-1:0] random_weight();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return {1'b1, 15'($urandom)};
            2, 3:    return WIN_W'($urandom_range(1, 4));   // ties
            4:       return 16'h7FFF;
            5, 6:    return {1'b0, 15'($urandom)};
            default: return WIN_W'($urandom);
        endcase
    endfunction

    task automatic send_txn(input logic [CMD_W-1:0] cmd, input logic signed [WIN_W-1:0] weight,
                            input bit typed = 1'b0, input edge_result_t typed_edge = NO_EDGE);
        int unsigned  gap;
        edge_result_t next_edge;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.weight_in <= weight;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        case (cmd)
            CMD_CLEAR:
            begin
                clear_matrix();
                useful_items++;
            end
            CMD_LOAD:
                if (sort_in_weight(weight)) useful_items++;
            CMD_READ:
            begin
                next_edge = next_sorted_edge();
                expected_edges.push_back(typed ? typed_edge : next_edge);
                useful_items++;
            end
            default: ;  // unused code, dropped by the block
        endcase
    endtask

    // called on a clock edge; drops valid and lets the block drain
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_count(input logic [NCFG_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        node_cfg     = value;
    endtask

    task automatic run_session(input logic [NCFG_W-1:0] nodes, input int unsigned read_cap,
                               input bit squeeze);
        int unsigned pairs;
        int unsigned n_reads;
        idling = ($urandom_range(0, 4) != 0);
        write_node_count(nodes);
        send_txn(CMD_CLEAR, random_weight());
        pairs = nodes_in_use();
        pairs = pairs * (pairs - 1) / 2;
        for (int unsigned k = 0; k < pairs; k++)
        begin
            // shrink the matrix part way through loading now and then
            if (k == pairs / 2 && $urandom_range(0, 3) == 0)
                write_node_count(NCFG_W'($urandom_range(0, nodes_in_use())));
            if ($urandom_range(0, 99) < 12) send_txn(CMD_READ, random_weight());
            if ($urandom_range(0, 99) < 3) send_txn(CMD_UNUSED, random_weight());
            if ($urandom_range(0, 99) < 2) send_txn(CMD_CLEAR, random_weight());
            send_txn(CMD_LOAD, random_weight());
        end
        repeat ($urandom_range(0, 3)) send_txn(CMD_LOAD, random_weight());
        if (squeeze)
        begin
            // receiver holds off while reads and loads keep coming
            hold_request = 1'b1;
            repeat (12)
                send_txn(($urandom_range(0, 9) < 7) ? CMD_READ : CMD_LOAD, random_weight());
        end
        n_reads = kept_edges - read_ptr + 1 + $urandom_range(0, 1);
        if (n_reads > read_cap) n_reads = read_cap;
        repeat (n_reads) send_txn(CMD_READ, random_weight());
    endtask

    // receiver side
    initial
    begin
        int unsigned stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            else
            begin
                stall = pick_gap();
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                for (int unsigned c = 0; c < stall; c++) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        edge_result_t seen;
        edge_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen = '{out_ch.edge_valid,
                     '{out_ch.node_low, out_ch.node_high, out_ch.edge_weight, out_ch.edge_id},
                     out_ch.last_edge};
            if (expected_edges.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction at cycle %0d: %s", cycle_count,
                             edge_text(seen));
            end
            else
            begin
                want = expected_edges.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at cycle %0d: expected %s, got %s", cycle_count,
                                 edge_text(want), edge_text(seen));
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.cmd       <= CMD_CLEAR;
        in_ch.weight_in <= '0;
        mismatches   = 0;
        useful_items = 0;
        idling       = 1'b1;
        hold_request = 1'b0;
        node_cfg     = 6'd32;
        clear_matrix();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_rows[i].kind == ROW_NODES)
                write_node_count(directed_rows[i].nodes);
            else
                send_txn(directed_rows[i].cmd, directed_rows[i].weight,
                         directed_rows[i].typed, directed_rows[i].result);
        end

        // one full-size matrix, read only from the shallow end to keep reads short
        run_session(6'd32, 30, 1'b0);
        run_session(6'd8, 200, 1'b1);
        while (useful_items < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:       run_session(NCFG_W'($urandom_range(0, 1)), 200, 1'b0);
                1, 2:    run_session(NCFG_W'($urandom_range(10, 16)), 200, 1'b0);
                default: run_session(NCFG_W'($urandom_range(2, 9)), 200, 1'b0);
            endcase
        end

        wait_idle();
        if (mismatches == 0 && expected_edges.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
